// File: hw/rtl/aes128_pkg.sv
// AES-128 package: S-box tables, GF(2^8) helpers and round functions.
// Used by the round stage module and the top level.
`timescale 1ns / 1ps
package aes128_pkg;

  localparam int unsigned NumRounds = 10;

  typedef logic [127:0] block_t;

  typedef struct packed {
    logic   kind;
    block_t state;
  } stage_t;

  function automatic logic [7:0] fwd_sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] dec_sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'h52; 8'h01: r=8'h09; 8'h02: r=8'h6a; 8'h03: r=8'hd5;
      8'h04: r=8'h30; 8'h05: r=8'h36; 8'h06: r=8'ha5; 8'h07: r=8'h38;
      8'h08: r=8'hbf; 8'h09: r=8'h40; 8'h0a: r=8'ha3; 8'h0b: r=8'h9e;
      8'h0c: r=8'h81; 8'h0d: r=8'hf3; 8'h0e: r=8'hd7; 8'h0f: r=8'hfb;
      8'h10: r=8'h7c; 8'h11: r=8'he3; 8'h12: r=8'h39; 8'h13: r=8'h82;
      8'h14: r=8'h9b; 8'h15: r=8'h2f; 8'h16: r=8'hff; 8'h17: r=8'h87;
      8'h18: r=8'h34; 8'h19: r=8'h8e; 8'h1a: r=8'h43; 8'h1b: r=8'h44;
      8'h1c: r=8'hc4; 8'h1d: r=8'hde; 8'h1e: r=8'he9; 8'h1f: r=8'hcb;
      8'h20: r=8'h54; 8'h21: r=8'h7b; 8'h22: r=8'h94; 8'h23: r=8'h32;
      8'h24: r=8'ha6; 8'h25: r=8'hc2; 8'h26: r=8'h23; 8'h27: r=8'h3d;
      8'h28: r=8'hee; 8'h29: r=8'h4c; 8'h2a: r=8'h95; 8'h2b: r=8'h0b;
      8'h2c: r=8'h42; 8'h2d: r=8'hfa; 8'h2e: r=8'hc3; 8'h2f: r=8'h4e;
      8'h30: r=8'h08; 8'h31: r=8'h2e; 8'h32: r=8'ha1; 8'h33: r=8'h66;
      8'h34: r=8'h28; 8'h35: r=8'hd9; 8'h36: r=8'h24; 8'h37: r=8'hb2;
      8'h38: r=8'h76; 8'h39: r=8'h5b; 8'h3a: r=8'ha2; 8'h3b: r=8'h49;
      8'h3c: r=8'h6d; 8'h3d: r=8'h8b; 8'h3e: r=8'hd1; 8'h3f: r=8'h25;
      8'h40: r=8'h72; 8'h41: r=8'hf8; 8'h42: r=8'hf6; 8'h43: r=8'h64;
      8'h44: r=8'h86; 8'h45: r=8'h68; 8'h46: r=8'h98; 8'h47: r=8'h16;
      8'h48: r=8'hd4; 8'h49: r=8'ha4; 8'h4a: r=8'h5c; 8'h4b: r=8'hcc;
      8'h4c: r=8'h5d; 8'h4d: r=8'h65; 8'h4e: r=8'hb6; 8'h4f: r=8'h92;
      8'h50: r=8'h6c; 8'h51: r=8'h70; 8'h52: r=8'h48; 8'h53: r=8'h50;
      8'h54: r=8'hfd; 8'h55: r=8'hed; 8'h56: r=8'hb9; 8'h57: r=8'hda;
      8'h58: r=8'h5e; 8'h59: r=8'h15; 8'h5a: r=8'h46; 8'h5b: r=8'h57;
      8'h5c: r=8'ha7; 8'h5d: r=8'h8d; 8'h5e: r=8'h9d; 8'h5f: r=8'h84;
      8'h60: r=8'h90; 8'h61: r=8'hd8; 8'h62: r=8'hab; 8'h63: r=8'h00;
      8'h64: r=8'h8c; 8'h65: r=8'hbc; 8'h66: r=8'hd3; 8'h67: r=8'h0a;
      8'h68: r=8'hf7; 8'h69: r=8'he4; 8'h6a: r=8'h58; 8'h6b: r=8'h05;
      8'h6c: r=8'hb8; 8'h6d: r=8'hb3; 8'h6e: r=8'h45; 8'h6f: r=8'h06;
      8'h70: r=8'hd0; 8'h71: r=8'h2c; 8'h72: r=8'h1e; 8'h73: r=8'h8f;
      8'h74: r=8'hca; 8'h75: r=8'h3f; 8'h76: r=8'h0f; 8'h77: r=8'h02;
      8'h78: r=8'hc1; 8'h79: r=8'haf; 8'h7a: r=8'hbd; 8'h7b: r=8'h03;
      8'h7c: r=8'h01; 8'h7d: r=8'h13; 8'h7e: r=8'h8a; 8'h7f: r=8'h6b;
      8'h80: r=8'h3a; 8'h81: r=8'h91; 8'h82: r=8'h11; 8'h83: r=8'h41;
      8'h84: r=8'h4f; 8'h85: r=8'h67; 8'h86: r=8'hdc; 8'h87: r=8'hea;
      8'h88: r=8'h97; 8'h89: r=8'hf2; 8'h8a: r=8'hcf; 8'h8b: r=8'hce;
      8'h8c: r=8'hf0; 8'h8d: r=8'hb4; 8'h8e: r=8'he6; 8'h8f: r=8'h73;
      8'h90: r=8'h96; 8'h91: r=8'hac; 8'h92: r=8'h74; 8'h93: r=8'h22;
      8'h94: r=8'he7; 8'h95: r=8'had; 8'h96: r=8'h35; 8'h97: r=8'h85;
      8'h98: r=8'he2; 8'h99: r=8'hf9; 8'h9a: r=8'h37; 8'h9b: r=8'he8;
      8'h9c: r=8'h1c; 8'h9d: r=8'h75; 8'h9e: r=8'hdf; 8'h9f: r=8'h6e;
      8'ha0: r=8'h47; 8'ha1: r=8'hf1; 8'ha2: r=8'h1a; 8'ha3: r=8'h71;
      8'ha4: r=8'h1d; 8'ha5: r=8'h29; 8'ha6: r=8'hc5; 8'ha7: r=8'h89;
      8'ha8: r=8'h6f; 8'ha9: r=8'hb7; 8'haa: r=8'h62; 8'hab: r=8'h0e;
      8'hac: r=8'haa; 8'had: r=8'h18; 8'hae: r=8'hbe; 8'haf: r=8'h1b;
      8'hb0: r=8'hfc; 8'hb1: r=8'h56; 8'hb2: r=8'h3e; 8'hb3: r=8'h4b;
      8'hb4: r=8'hc6; 8'hb5: r=8'hd2; 8'hb6: r=8'h79; 8'hb7: r=8'h20;
      8'hb8: r=8'h9a; 8'hb9: r=8'hdb; 8'hba: r=8'hc0; 8'hbb: r=8'hfe;
      8'hbc: r=8'h78; 8'hbd: r=8'hcd; 8'hbe: r=8'h5a; 8'hbf: r=8'hf4;
      8'hc0: r=8'h1f; 8'hc1: r=8'hdd; 8'hc2: r=8'ha8; 8'hc3: r=8'h33;
      8'hc4: r=8'h88; 8'hc5: r=8'h07; 8'hc6: r=8'hc7; 8'hc7: r=8'h31;
      8'hc8: r=8'hb1; 8'hc9: r=8'h12; 8'hca: r=8'h10; 8'hcb: r=8'h59;
      8'hcc: r=8'h27; 8'hcd: r=8'h80; 8'hce: r=8'hec; 8'hcf: r=8'h5f;
      8'hd0: r=8'h60; 8'hd1: r=8'h51; 8'hd2: r=8'h7f; 8'hd3: r=8'ha9;
      8'hd4: r=8'h19; 8'hd5: r=8'hb5; 8'hd6: r=8'h4a; 8'hd7: r=8'h0d;
      8'hd8: r=8'h2d; 8'hd9: r=8'he5; 8'hda: r=8'h7a; 8'hdb: r=8'h9f;
      8'hdc: r=8'h93; 8'hdd: r=8'hc9; 8'hde: r=8'h9c; 8'hdf: r=8'hef;
      8'he0: r=8'ha0; 8'he1: r=8'he0; 8'he2: r=8'h3b; 8'he3: r=8'h4d;
      8'he4: r=8'hae; 8'he5: r=8'h2a; 8'he6: r=8'hf5; 8'he7: r=8'hb0;
      8'he8: r=8'hc8; 8'he9: r=8'heb; 8'hea: r=8'hbb; 8'heb: r=8'h3c;
      8'hec: r=8'h83; 8'hed: r=8'h53; 8'hee: r=8'h99; 8'hef: r=8'h61;
      8'hf0: r=8'h17; 8'hf1: r=8'h2b; 8'hf2: r=8'h04; 8'hf3: r=8'h7e;
      8'hf4: r=8'hba; 8'hf5: r=8'h77; 8'hf6: r=8'hd6; 8'hf7: r=8'h26;
      8'hf8: r=8'he1; 8'hf9: r=8'h69; 8'hfa: r=8'h14; 8'hfb: r=8'h63;
      8'hfc: r=8'h55; 8'hfd: r=8'h21; 8'hfe: r=8'h0c; 8'hff: r=8'h7d;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Byte n of the state sits at bits 127-8n : 120-8n.
  function automatic logic [7:0] get_byte(input block_t s, input int n);
    return s[127-8*n -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // Forward round without key add; last round skips MixColumns.
  function automatic block_t enc_round(input block_t s, input logic last);
    block_t     t;
    block_t     m;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(r+4*c) -: 8] = fwd_sbox(get_byte(s, r + 4*((c+r) & 3)));
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(t, 4*c);   a1 = get_byte(t, 4*c+1);
      a2 = get_byte(t, 4*c+2); a3 = get_byte(t, 4*c+3);
      m[127-8*(4*c)   -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      m[127-8*(4*c+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      m[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      m[127-8*(4*c+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return last ? t : m;
  endfunction

  function automatic logic [7:0] gmul_inv(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] x2, x4, x8;
    x2 = xtime(a);
    x4 = xtime(x2);
    x8 = xtime(x4);
    return (b[0] ? a : 8'h00) ^ (b[1] ? x2 : 8'h00) ^ (b[2] ? x4 : 8'h00)
         ^ (b[3] ? x8 : 8'h00);
  endfunction

  function automatic block_t inv_mix(input block_t s);
    block_t     m;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);   a1 = get_byte(s, 4*c+1);
      a2 = get_byte(s, 4*c+2); a3 = get_byte(s, 4*c+3);
      m[127-8*(4*c)   -: 8] = gmul_inv(a0, 4'd14) ^ gmul_inv(a1, 4'd11)
                            ^ gmul_inv(a2, 4'd13) ^ gmul_inv(a3, 4'd9);
      m[127-8*(4*c+1) -: 8] = gmul_inv(a0, 4'd9) ^ gmul_inv(a1, 4'd14)
                            ^ gmul_inv(a2, 4'd11) ^ gmul_inv(a3, 4'd13);
      m[127-8*(4*c+2) -: 8] = gmul_inv(a0, 4'd13) ^ gmul_inv(a1, 4'd9)
                            ^ gmul_inv(a2, 4'd14) ^ gmul_inv(a3, 4'd11);
      m[127-8*(4*c+3) -: 8] = gmul_inv(a0, 4'd11) ^ gmul_inv(a1, 4'd13)
                            ^ gmul_inv(a2, 4'd9) ^ gmul_inv(a3, 4'd14);
    end
    return m;
  endfunction

  function automatic block_t inv_shift_sub(input block_t s);
    block_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(r+4*((c+r) & 3)) -: 8] = dec_sbox(get_byte(s, r + 4*c));
      end
    end
    return t;
  endfunction

  // One key schedule step: next round key from previous one.
  function automatic block_t key_step(input block_t k, input logic [7:0] rc);
    block_t     n;
    logic [31:0] t;
    t = {fwd_sbox(k[23:16]) ^ rc, fwd_sbox(k[15:8]), fwd_sbox(k[7:0]),
         fwd_sbox(k[31:24])};
    n[127:96] = k[127:96] ^ t;
    n[95:64]  = k[95:64] ^ n[127:96];
    n[63:32]  = k[63:32] ^ n[95:64];
    n[31:0]   = k[31:0] ^ n[63:32];
    return n;
  endfunction

  function automatic logic [7:0] rcon(input int i);
    logic [7:0] r;
    r = 8'h01;
    for (int j = 0; j < i; j++) r = xtime(r);
    return r;
  endfunction

endpackage

// File: hw/rtl/aes128_if.sv
// Valid/ready stream interfaces for the cipher core.
// Blocks are carried as two 64-bit halves; no package is imported.
`timescale 1ns / 1ps
interface aes128_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [63:0] block_high;
  logic [63:0] block_low;
  modport source (output valid, kind, block_high, block_low, input ready);
  modport sink (input valid, kind, block_high, block_low, output ready);
endinterface

interface aes128_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  modport source (output valid, result_high, result_low, input ready);
  modport sink (input valid, result_high, result_low, output ready);
endinterface

// File: hw/rtl/aes128_round.sv
// One pipelined cipher round, both directions, with its registers.
// Depends on aes128_pkg.
`timescale 1ns / 1ps
module aes128_round #(
  parameter int unsigned Round = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  aes128_pkg::stage_t   data_i,
  input  aes128_pkg::block_t   enc_key_i,
  input  aes128_pkg::block_t   dec_key_i,
  output logic                 valid_o,
  output aes128_pkg::stage_t   data_o
);
  import aes128_pkg::*;

  localparam logic IsLast = (Round == NumRounds);

  logic   valid_q;
  stage_t data_q, data_d;
  block_t dec_v;

  // Encrypt: forward round, then key add. Decrypt: InvShift/InvSub, key add, then InvMix except on the last round.
  always_comb begin
    dec_v = inv_shift_sub(data_i.state) ^ dec_key_i;
    data_d.kind = data_i.kind;
    if (!data_i.kind) begin
      data_d.state = enc_round(data_i.state, IsLast) ^ enc_key_i;
    end else begin
      data_d.state = IsLast ? dec_v : inv_mix(dec_v);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

// File: hw/rtl/aes128_block_cipher_core.sv
// AES-128 encrypt/decrypt core, fully unrolled ten-round pipeline.
// Depends on aes128_pkg, aes128_if and aes128_round.
//
// Usage:
//   Input channel carries kind (0 encrypt, 1 decrypt) and a 128-bit block
//   split into block_high/block_low. Output channel returns result_high/low.
//   Key is written through cfg_we_i/cfg_idx_i/cfg_wdata_i: index 0 key_high,
//   index 1 key_low; the index is one bit wide. Write only while idle.
//   Round keys are expanded by a second pipeline, one step per cycle; in.ready
//   stays low after each key write while they settle.
// Pipeline: 11 register stages (input key add plus ten rounds). Throughput: one item
//   per cycle while the output is not stalled and no round keys are settling.
// The pipeline advances as a whole; when the output holds a valid result
//   and the receiver stalls, every stage holds and in.ready drops. Internal bubbles
//   are not squeezed out; with the output empty, ready is high once keys settle.
// Reset clears all valid bits and the key to zero; in.ready stays low after
//   reset while the round keys settle from the zero key.
`timescale 1ns / 1ps
module aes128_block_cipher_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  aes128_in_if.sink   in_i,
  aes128_out_if.source out_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [63:0] cfg_wdata_i
);
  import aes128_pkg::*;

  localparam logic CfgKeyHigh = 1'b0;
  localparam logic CfgKeyLow  = 1'b1;
  localparam logic [3:0] KeyWait = 4'(NumRounds + 1);

  logic [63:0] key_high_q, key_low_q;
  block_t      rk_q [NumRounds+1];
  logic        en;
  logic        valid_s [NumRounds+1];
  stage_t      data_s [NumRounds+1];
  logic        v0_q;
  stage_t      d0_q;
  block_t      in_blk;
  logic [3:0]  key_wait_q, key_wait_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgKeyHigh: key_high_q <= cfg_wdata_i;
        CfgKeyLow:  key_low_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Key schedule pipeline: one key step per register after the key copy in rk_q[0].
  always_ff @(posedge clk_i) begin
    rk_q[0] <= {key_high_q, key_low_q};
    for (int i = 1; i <= NumRounds; i++) begin
      rk_q[i] <= key_step(rk_q[i-1], rcon(i-1));
    end
  end

  // Input is held off until the last round key reflects the current key.
  always_comb begin
    if (cfg_we_i) begin
      key_wait_d = KeyWait;
    end else if (key_wait_q != 4'd0) begin
      key_wait_d = key_wait_q - 4'd1;
    end else begin
      key_wait_d = key_wait_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_wait_q <= KeyWait;
    end else begin
      key_wait_q <= key_wait_d;
    end
  end

  assign en          = !out_o.valid || out_o.ready;
  assign in_i.ready  = en && (key_wait_q == 4'd0);
  assign in_blk      = {in_i.block_high, in_i.block_low};

  // Initial key add: round key 0 for encrypt, round key 10 for decrypt.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_i.valid && in_i.ready;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d0_q.kind  <= in_i.kind;
      d0_q.state <= in_blk ^ (in_i.kind ? rk_q[NumRounds] : rk_q[0]);
    end
  end

  assign valid_s[0] = v0_q;
  assign data_s[0]  = d0_q;

  for (genvar g = 1; g <= NumRounds; g++) begin : g_round
    aes128_round #(.Round(g)) u_round (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .valid_i   (valid_s[g-1]),
      .data_i    (data_s[g-1]),
      .enc_key_i (rk_q[g]),
      .dec_key_i (rk_q[NumRounds-g]),
      .valid_o   (valid_s[g]),
      .data_o    (data_s[g])
    );
  end

  assign out_o.valid       = valid_s[NumRounds];
  assign out_o.result_high = data_s[NumRounds].state[127:64];
  assign out_o.result_low  = data_s[NumRounds].state[63:0];

  // A stalled result must hold until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.result_high))
    else $error("result changed under stall");

  // Input is never accepted while the output is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (!out_o.valid || out_o.ready))
    else $error("ready high under output stall");

  // An item in the key-add stage reaches the first round register whenever the
  // pipeline is enabled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_s[0] && en |=> valid_s[1])
    else $error("item lost in first round");
endmodule

// File: dv/aes128_block_cipher_core_test.sv
// Testbench for the AES-128 encrypt/decrypt core: directed vectors, random items,
// then a long output hold. Results are checked against an in-bench AES predictor.
// Needs aes128_pkg, aes128_if and the core RTL.
`timescale 1ns / 1ps
module aes128_block_cipher_core_test;

  typedef enum logic {KIND_ENC = 1'b0, KIND_DEC = 1'b1} kind_e;
  localparam logic KEY_HIGH_IDX = 1'b0;
  localparam logic KEY_LOW_IDX  = 1'b1;
  localparam int   KEY_SETTLE   = 16;
  localparam int   STALL_LIMIT  = 20000;

  typedef struct {
    logic [63:0] res_high;
    logic [63:0] res_low;
  } block_pair_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [63:0] cfg_wdata_i = '0;

  aes128_in_if  blk_in();
  aes128_out_if blk_out();

  aes128_block_cipher_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (blk_in),
    .out_o      (blk_out),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  logic [7:0]  sbox_fwd [256];
  logic [7:0]  sbox_inv [256];
  logic [63:0] key_high_q = '0;
  logic [63:0] key_low_q = '0;
  block_pair_t cipher_pending [$];
  int          errors = 0;
  int          tx_gap_pct = 0;
  int          rx_stall_pct = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;
  int          sent_items = 0;
  int          checked_items = 0;
  int          key_loads = 0;

  // ---------------- predictor ----------------
  function automatic logic [7:0] gf_dbl(logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    acc = '0;
    while (b != 0) begin
      if (b[0]) acc ^= a;
      a = gf_dbl(a);
      b = b >> 1;
    end
    return acc;
  endfunction

  // S-box from the field inverse plus the affine map
  function automatic void build_sboxes();
    logic [7:0] inv, s;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int y = 1; y < 256; y++)
        if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sbox_fwd[x] = s;
      sbox_inv[s] = x[7:0];
    end
  endfunction

  function automatic logic [127:0] aes_block(kind_e kind, logic [127:0] key,
                                             logic [127:0] blk);
    logic [7:0] rk [176];
    logic [7:0] st [16];
    logic [7:0] tmp [16];
    logic [7:0] w [4];
    logic [7:0] fwd_base [4];
    logic [7:0] inv_base [4];
    logic [7:0] rc, x, v;
    logic [127:0] res;
    fwd_base = '{8'd2, 8'd3, 8'd1, 8'd1};
    inv_base = '{8'd14, 8'd11, 8'd13, 8'd9};
    rc = 8'h01;
    for (int n = 0; n < 16; n++) begin
      rk[n] = key[127-8*n -: 8];
      st[n] = blk[127-8*n -: 8];
    end
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) w[j] = rk[i-4+j];
      if (i % 16 == 0) begin
        x = w[0];
        w[0] = sbox_fwd[w[1]] ^ rc;
        w[1] = sbox_fwd[w[2]];
        w[2] = sbox_fwd[w[3]];
        w[3] = sbox_fwd[x];
        rc = gf_dbl(rc);
      end
      for (int j = 0; j < 4; j++) rk[i+j] = rk[i-16+j] ^ w[j];
    end
    if (kind == KIND_ENC) begin
      for (int n = 0; n < 16; n++) st[n] ^= rk[n];
      for (int rnd = 1; rnd <= 10; rnd++) begin
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++)
            tmp[r+4*c] = sbox_fwd[st[r+4*((c+r)&3)]];
        if (rnd < 10) begin
          for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
              v = '0;
              for (int k = 0; k < 4; k++) v ^= gf_mul(fwd_base[(k-r)&3], tmp[k+4*c]);
              st[r+4*c] = v;
            end
        end else st = tmp;
        for (int n = 0; n < 16; n++) st[n] ^= rk[16*rnd+n];
      end
    end else begin
      for (int n = 0; n < 16; n++) st[n] ^= rk[160+n];
      for (int rnd = 9; rnd >= 0; rnd--) begin
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++)
            tmp[r+4*((c+r)&3)] = sbox_inv[st[r+4*c]];
        for (int n = 0; n < 16; n++) tmp[n] ^= rk[16*rnd+n];
        if (rnd > 0) begin
          for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
              v = '0;
              for (int k = 0; k < 4; k++) v ^= gf_mul(inv_base[(k-r)&3], tmp[k+4*c]);
              st[r+4*c] = v;
            end
        end else st = tmp;
      end
    end
    for (int n = 0; n < 16; n++) res[127-8*n -: 8] = st[n];
    return res;
  endfunction

  // ---------------- drivers ----------------
  task automatic send_block(kind_e kind, logic [63:0] hi, logic [63:0] lo);
    block_pair_t exp_res;
    logic [127:0] r;
    if (tx_gap_pct > 0 && $urandom_range(99) < tx_gap_pct) begin
      blk_in.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    blk_in.valid      <= 1'b1;
    blk_in.kind       <= kind;
    blk_in.block_high <= hi;
    blk_in.block_low  <= lo;
    @(posedge clk_i);
    while (!blk_in.ready) @(posedge clk_i);
    r = aes_block(kind, {key_high_q, key_low_q}, {hi, lo});
    exp_res.res_high = r[127:64];
    exp_res.res_low  = r[63:0];
    cipher_pending.push_back(exp_res);
    sent_items++;
  endtask

  task automatic drain_pipeline();
    blk_in.valid <= 1'b0;
    @(posedge clk_i);
    while (cipher_pending.size() != 0) @(posedge clk_i);
    repeat (KEY_SETTLE) @(posedge clk_i);
  endtask

  task automatic load_key(logic [63:0] hi, logic [63:0] lo);
    drain_pipeline();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= KEY_HIGH_IDX;
    cfg_wdata_i <= hi;
    @(posedge clk_i);
    cfg_idx_i   <= KEY_LOW_IDX;
    cfg_wdata_i <= lo;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    key_high_q = hi;
    key_low_q  = lo;
    key_loads++;
    // round keys are rebuilt by their own pipeline
    repeat (KEY_SETTLE) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      blk_out.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      blk_out.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // ---------------- checker and watchdog ----------------
  always @(posedge clk_i) begin
    block_pair_t exp_res;
    if (rst_ni && blk_out.valid && blk_out.ready) begin
      if (cipher_pending.size() == 0) begin
        $error("result with no pending item: %h %h", blk_out.result_high,
               blk_out.result_low);
        errors++;
      end else begin
        exp_res = cipher_pending.pop_front();
        checked_items++;
        if (blk_out.result_high !== exp_res.res_high) begin
          $error("result_high expected %h got %h", exp_res.res_high, blk_out.result_high);
          errors++;
        end
        if (blk_out.result_low !== exp_res.res_low) begin
          $error("result_low expected %h got %h", exp_res.res_low, blk_out.result_low);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((blk_in.valid && blk_in.ready) || (blk_out.valid && blk_out.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------- tests ----------------
  task automatic test_zero_key();
    send_block(KIND_ENC, 64'h0, 64'h0);
    send_block(KIND_DEC, 64'h0, 64'h0);
    send_block(KIND_ENC, '1, '1);
    send_block(KIND_DEC, '1, '1);
  endtask

  task automatic test_known_vectors();
    logic [127:0] ct;
    load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    ct = aes_block(KIND_ENC, {key_high_q, key_low_q}, 128'h00112233445566778899aabbccddeeff);
    if (ct !== 128'h69c4e0d86a7b0430d8cdb78070b4c55a) begin
      $error("predictor vector expected %h got %h",
             128'h69c4e0d86a7b0430d8cdb78070b4c55a, ct);
      errors++;
    end
    send_block(KIND_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(KIND_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    send_block(KIND_ENC, 64'h8000000000000000, 64'h0000000000000001);
    send_block(KIND_DEC, 64'h0000000000000001, 64'h8000000000000000);
  endtask

  task automatic test_key_extremes();
    load_key('1, '1);
    send_block(KIND_ENC, '0, '0);
    send_block(KIND_ENC, '1, '1);
    send_block(KIND_DEC, '0, '1);
    send_block(KIND_DEC, '1, '0);
    load_key(64'h8000000000000000, 64'h0000000000000001);
    send_block(KIND_ENC, 64'h0123456789abcdef, 64'hfedcba9876543210);
    send_block(KIND_DEC, 64'h0123456789abcdef, 64'hfedcba9876543210);
  endtask

  // plaintext round trips (encrypt, then decrypt the expected ciphertext) or lone items
  task automatic test_random(int items, int tx_pct, int rx_pct);
    logic [127:0] pt, ct;
    kind_e        k;
    tx_gap_pct   = tx_pct;
    rx_stall_pct = rx_pct;
    for (int i = 0; i < items; i++) begin
      if (i % 110 == 0) load_key(rand64(), rand64());
      pt = {rand64(), rand64()};
      if ($urandom_range(3) == 0) begin
        k = $urandom_range(1) ? KIND_DEC : KIND_ENC;
        send_block(k, pt[127:64], pt[63:0]);
      end else begin
        ct = aes_block(KIND_ENC, {key_high_q, key_low_q}, pt);
        send_block(KIND_ENC, pt[127:64], pt[63:0]);
        send_block(KIND_DEC, ct[127:64], ct[63:0]);
        i++;
      end
    end
  endtask

  task automatic test_backpressure();
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    drain_pipeline();
    hold_left <= 400;
    for (int i = 0; i < 60; i++) send_block(i[0] ? KIND_DEC : KIND_ENC, rand64(), rand64());
  endtask

  initial begin
    blk_in.valid      = 1'b0;
    blk_in.kind       = KIND_ENC;
    blk_in.block_high = '0;
    blk_in.block_low  = '0;
    blk_out.ready     = 1'b0;
    build_sboxes();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (KEY_SETTLE) @(posedge clk_i);

    test_zero_key();
    test_known_vectors();
    test_key_extremes();
    test_random(330, 7, 58);
    test_random(330, 58, 7);
    test_random(330, 0, 0);
    test_backpressure();

    drain_pipeline();
    $display("Covered %0d items (encrypt, decrypt, round trips) under %0d key loads,",
             sent_items, key_loads);
    $display("with sender gaps, receiver stalls and a long output hold; %0d checked.",
             checked_items);
    if (errors == 0 && cipher_pending.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: aes128_block_cipher_core.f
hw/rtl/aes128_pkg.sv
hw/rtl/aes128_if.sv
hw/rtl/aes128_round.sv
hw/rtl/aes128_block_cipher_core.sv
dv/aes128_block_cipher_core_test.sv
